// ----- hdl/b64d_pkg.sv -----
`default_nettype none
package b64d_pkg;

	typedef enum logic [1:0] {
		ST_BYTE    = 2'd0,
		ST_DONE    = 2'd1,
		ST_BADCHAR = 2'd2,
		ST_LENGTH  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		status_t    status;
		logic       run_last;
	} res_t;

	localparam int unsigned MaxResults = 4;
	localparam int unsigned FifoDepth  = 8;
	localparam int unsigned PtrW       = $clog2(FifoDepth);
	localparam int unsigned CntW       = $clog2(FifoDepth + 1);
	localparam int unsigned NumW       = $clog2(MaxResults + 1);

	localparam logic [6:0] CLS_SKIP = 7'd64;
	localparam logic [6:0] CLS_BAD  = 7'd65;

	localparam logic [5:0] LowerBase = 6'd26;
	localparam logic [5:0] DigitBase = 6'd52;
	localparam logic [5:0] DashCode  = 6'd62;
	localparam logic [5:0] UnderCode = 6'd63;

	function automatic logic [6:0] classify(input logic [7:0] c);
		logic [6:0] r;
		r = CLS_BAD;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = {1'b0, 6'(c - 8'h41)};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = {1'b0, 6'(c - 8'h61) + LowerBase};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 6'(c - 8'h30) + DigitBase};
		end else if (c == 8'h2D) begin
			r = {1'b0, DashCode};
		end else if (c == 8'h5F) begin
			r = {1'b0, UnderCode};
		end else if ((c >= 8'h09 && c <= 8'h0D) || c == 8'h20) begin
			r = CLS_SKIP;
		end
		return r;
	endfunction

	function automatic logic [7:0] byte0(input logic [5:0] a, input logic [5:0] b);
		return {a, b[5:4]};
	endfunction

	function automatic logic [7:0] byte1(input logic [5:0] b, input logic [5:0] c);
		return {b[3:0], c[5:2]};
	endfunction

	function automatic logic [7:0] byte2(input logic [5:0] c, input logic [5:0] d);
		return {c[1:0], d};
	endfunction

endpackage
`default_nettype wire

// ----- hdl/b64d_sym_if.sv -----
`default_nettype none
interface b64d_sym_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       final_symbol;

	modport source(output valid, output symbol, output final_symbol, input ready);
	modport sink(input valid, input symbol, input final_symbol, output ready);
endinterface
`default_nettype wire

// ----- hdl/b64d_res_if.sv -----
`default_nettype none
interface b64d_res_if;
	logic              valid;
	logic              ready;
	logic [7:0]        data_byte;
	b64d_pkg::status_t status;
	logic              run_last;

	modport source(output valid, output data_byte, output status, output run_last, input ready);
	modport sink(input valid, input data_byte, input status, input run_last, output ready);
endinterface
`default_nettype wire

// ----- hdl/base64url_stream_decoder.sv -----
// Channel   Direction  Request contents
// symbols   in         symbol[7:0], final_symbol
// results   out        data_byte[7:0], status[1:0], run_last
//
// One character request is taken per cycle into an input register. The decode stage reads
// it there and writes its zero to four results into an eight-entry result queue at once.
// The decode stage advances whenever the queue has room for four results, so input
// stalls only when the result side is held off. Results leave the queue one per cycle while results.ready is high.
// Reset clears the held symbols, the error flag and the queue.
`default_nettype none
module base64url_stream_decoder (
	input  wire logic clk,
	input  wire logic arst_n,
	b64d_sym_if.sink  symbols,
	b64d_res_if.source results
);
	import b64d_pkg::*;

	logic       valid_s1;
	logic [7:0] symbol_s1;
	logic       final_s1;

	logic [1:0] held_cnt_q;
	logic [5:0] held_q [3];
	logic       err_q;

	res_t            fifo_q [FifoDepth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;

	logic            fire_s1;
	logic            pop;
	logic [6:0]      cls;
	logic [NumW-1:0] num;
	res_t            res [MaxResults];
	logic [1:0]      held_cnt_n;
	logic [5:0]      held_n [3];
	logic            err_n;

	assign fire_s1       = valid_s1 && (cnt_q <= CntW'(FifoDepth - MaxResults));
	assign symbols.ready = !valid_s1 || fire_s1;
	assign pop           = results.valid && results.ready;

	assign results.valid     = (cnt_q != '0);
	assign results.data_byte = fifo_q[rd_q].data_byte;
	assign results.status    = fifo_q[rd_q].status;
	assign results.run_last  = fifo_q[rd_q].run_last;

	assign cls = classify(symbol_s1);

	always_comb begin
		logic [1:0] k;
		num        = '0;
		held_cnt_n = held_cnt_q;
		held_n     = held_q;
		err_n      = err_q;
		k          = held_cnt_q;
		for (int i = 0; i < MaxResults; i++) begin
			res[i] = '{data_byte: 8'd0, status: ST_BYTE, run_last: 1'b0};
		end
		if (err_q) begin
			if (final_s1) begin
				err_n = 1'b0;
				held_cnt_n = 2'd0;
				held_n = '{default: 6'd0};
			end
		end else if (cls == CLS_BAD) begin
			res[0].status = ST_BADCHAR;
			num = NumW'(1);
			err_n = !final_s1;
			if (final_s1) begin
				held_cnt_n = 2'd0;
				held_n = '{default: 6'd0};
			end
		end else begin
			if (cls != CLS_SKIP) begin
				if (k == 2'd3) begin
					res[0].data_byte = byte0(held_q[0], held_q[1]);
					res[1].data_byte = byte1(held_q[1], held_q[2]);
					res[2].data_byte = byte2(held_q[2], cls[5:0]);
					num = NumW'(3);
					k = 2'd0;
				end else begin
					case (k)
						2'd0: held_n[0] = cls[5:0];
						2'd1: held_n[1] = cls[5:0];
						default: held_n[2] = cls[5:0];
					endcase
					k = k + 2'd1;
				end
			end
			held_cnt_n = k;
			if (final_s1) begin
				if (k == 2'd1) begin
					res[num[1:0]].status = ST_LENGTH;
					num = num + NumW'(1);
				end else begin
					if (k >= 2'd2) begin
						res[num[1:0]].data_byte = byte0(held_n[0], held_n[1]);
						num = num + NumW'(1);
					end
					if (k == 2'd3) begin
						res[num[1:0]].data_byte = byte1(held_n[1], held_n[2]);
						num = num + NumW'(1);
					end
					res[num[1:0]].status = ST_DONE;
					num = num + NumW'(1);
				end
				held_cnt_n = 2'd0;
				held_n = '{default: 6'd0};
			end
		end
		for (int i = 0; i < MaxResults; i++) begin
			res[i].run_last = (NumW'(i + 1) == num);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			held_cnt_q <= 2'd0;
			held_q     <= '{default: 6'd0};
			err_q      <= 1'b0;
			wr_q       <= '0;
			rd_q       <= '0;
			cnt_q      <= '0;
		end else begin
			if (symbols.ready) begin
				valid_s1 <= symbols.valid;
			end
			if (fire_s1) begin
				held_cnt_q <= held_cnt_n;
				held_q     <= held_n;
				err_q      <= err_n;
				wr_q       <= wr_q + PtrW'(num);
			end
			if (pop) begin
				rd_q <= rd_q + PtrW'(1);
			end
			cnt_q <= cnt_q + (fire_s1 ? CntW'(num) : CntW'(0)) - (pop ? CntW'(1) : CntW'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (symbols.valid && symbols.ready) begin
			symbol_s1 <= symbols.symbol;
			final_s1  <= symbols.final_symbol;
		end
		if (fire_s1) begin
			for (int i = 0; i < MaxResults; i++) begin
				if (NumW'(i) < num) begin
					fifo_q[wr_q + PtrW'(i)] <= res[i];
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- sim/base64url_stream_decoder_tb.sv -----
`timescale 1ns / 1ps
module base64url_stream_decoder_tb;
	import b64d_pkg::*;

	localparam int RandomItems = 180;
	localparam int CycleLimit  = 200000;
	localparam int DrainCycles = 30;
	localparam int HoldCycles  = 120;

	localparam logic [8:0] DIRECTED [0:24] = '{
		9'h054, 9'h057, 9'h046, 9'h175,
		9'h039, 9'h009, 9'h030, 9'h00a, 9'h061, 9'h00b, 9'h07a, 9'h00c,
		9'h02d, 9'h00d, 9'h05f, 9'h120,
		9'h15a,
		9'h000, 9'h041, 9'h1ff,
		9'h1ff,
		9'h120,
		9'h041, 9'h042, 9'h143
	};

	class b64d_scoreboard;
		res_t       expected_q[$];
		logic [1:0] held_count;
		logic [5:0] held_syms[3];
		bit         error_seen;
		int         errors;
		int         kind_count[4];

		function new();
			clear_state();
			errors = 0;
			foreach (kind_count[i]) kind_count[i] = 0;
		endfunction

		function void clear_state();
			held_count = 2'd0;
			foreach (held_syms[i]) held_syms[i] = 6'd0;
			error_seen = 1'b0;
		endfunction

		function logic [6:0] sym_value(logic [7:0] c);
			if (c >= 8'h41 && c <= 8'h5a) return 7'(c - 8'h41);
			if (c >= 8'h61 && c <= 8'h7a) return 7'(c - 8'h61 + 8'd26);
			if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
			if (c == 8'h2d) return 7'd62;
			if (c == 8'h5f) return 7'd63;
			if ((c >= 8'h09 && c <= 8'h0d) || c == 8'h20) return CLS_SKIP;
			return CLS_BAD;
		endfunction

		function void push(logic [7:0] data, status_t st);
			res_t r;
			r.data_byte = data;
			r.status = st;
			r.run_last = 1'b0;
			expected_q.insert(expected_q.size(), r);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Returns 1 when the request is swallowed because an error is pending.
		function bit note_request(logic [7:0] sym, logic fin);
			logic [6:0]  cls;
			logic [23:0] word;
			int          first;
			first = expected_q.size();
			if (error_seen) begin
				if (fin) clear_state();
				return 1'b1;
			end
			cls = sym_value(sym);
			if (cls == CLS_BAD) begin
				push(8'd0, ST_BADCHAR);
				if (fin) clear_state();
				else error_seen = 1'b1;
			end else begin
				if (cls != CLS_SKIP) begin
					if (held_count == 2'd3) begin
						word = {held_syms[0], held_syms[1], held_syms[2], cls[5:0]};
						push(word[23:16], ST_BYTE);
						push(word[15:8], ST_BYTE);
						push(word[7:0], ST_BYTE);
						held_count = 2'd0;
					end else begin
						held_syms[held_count] = cls[5:0];
						held_count = held_count + 2'd1;
					end
				end
				if (fin) begin
					word = {held_syms[0], held_syms[1], held_syms[2], 6'd0};
					case (held_count)
						2'd1: begin
							push(8'd0, ST_LENGTH);
						end
						2'd2: begin
							push(word[23:16], ST_BYTE);
							push(8'd0, ST_DONE);
						end
						2'd3: begin
							push(word[23:16], ST_BYTE);
							push(word[15:8], ST_BYTE);
							push(8'd0, ST_DONE);
						end
						default: begin
							push(8'd0, ST_DONE);
						end
					endcase
					clear_state();
				end
			end
			if (expected_q.size() > first) expected_q[expected_q.size() - 1].run_last = 1'b1;
			return 1'b0;
		endfunction

		function void check_result(logic [7:0] data, status_t st, logic last);
			res_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result: data_byte %0d status %0d run_last %0d",
					data, st, last);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			kind_count[want.status]++;
			if (data !== want.data_byte) begin
				$error("mismatch on data_byte: expected %0d, actual %0d", want.data_byte, data);
				errors++;
			end
			if (st !== want.status) begin
				$error("mismatch on status: expected %0d, actual %0d", want.status, st);
				errors++;
			end
			if (last !== want.run_last) begin
				$error("mismatch on run_last: expected %0d, actual %0d", want.run_last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;

	b64d_sym_if sym_ch();
	b64d_res_if res_ch();

	base64url_stream_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.symbols(sym_ch),
		.results(res_ch)
	);

	b64d_scoreboard sb = new();
	int counted       = 0;
	int ignored_total = 0;
	int results_taken = 0;
	int input_stalls  = 0;
	int cycle_count   = 0;
	bit no_idle       = 1'b0;
	bit held_long     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 2) != 0) return 0;
		if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [7:0] b64_char(int unsigned v);
		if (v < 26) return 8'(8'h41 + v);
		if (v < 52) return 8'(8'h61 + v - 26);
		if (v < 62) return 8'(8'h30 + v - 52);
		if (v == 62) return 8'h2d;
		return 8'h5f;
	endfunction

	function automatic logic [7:0] skip_char();
		int unsigned r;
		r = $urandom_range(0, 5);
		if (r == 5) return 8'h20;
		return 8'(8'h09 + r);
	endfunction

	function automatic logic [7:0] bad_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (sb.sym_value(c) != CLS_BAD);
		return c;
	endfunction

	task automatic send_char(input logic [7:0] sym, input logic fin);
		int gap;
		sym_ch.valid <= 1'b1;
		sym_ch.symbol <= sym;
		sym_ch.final_symbol <= fin;
		do @(posedge clk); while (!sym_ch.ready);
		if (sb.note_request(sym, fin)) ignored_total++;
		else counted++;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			sym_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int unsigned kind;
		int          len;
		int          bad_at;
		bit          ws_tail;
		logic [7:0]  sym;
		sym_ch.valid <= 1'b0;
		sym_ch.symbol <= 8'd0;
		sym_ch.final_symbol <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) send_char(DIRECTED[i][7:0], DIRECTED[i][8]);

		while (counted + ignored_total < RandomItems) begin
			kind = $urandom_range(0, 9);
			no_idle = ($urandom_range(0, 3) == 0);
			if (kind < 8) begin
				len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
				bad_at = (kind == 7) ? $urandom_range(0, len - 1) : -1;
				ws_tail = ($urandom_range(0, 5) == 0);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 7) == 0) send_char(skip_char(), 1'b0);
					sym = (i == bad_at) ? bad_char() : b64_char($urandom_range(0, 63));
					send_char(sym, (i == len - 1) && !ws_tail);
				end
				if (ws_tail) send_char(skip_char(), 1'b1);
			end else begin
				repeat ($urandom_range(1, 4))
					send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end
		end
		sym_ch.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d counted requests plus %0d swallowed after errors; %0d results checked.",
			counted, ignored_total, results_taken);
		$display("Bytes %0d, done %0d, bad character %0d, short tail %0d; input stalled %0d cycles.",
			sb.kind_count[ST_BYTE], sb.kind_count[ST_DONE], sb.kind_count[ST_BADCHAR],
			sb.kind_count[ST_LENGTH], input_stalls);
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// The long hold-off lets the result queue fill so the input side backs up.
	initial begin
		int gap;
		res_ch.ready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held_long && results_taken >= 40) begin
				res_ch.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				held_long = 1'b1;
			end
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				sb.check_result(res_ch.data_byte, res_ch.status, res_ch.run_last);
				results_taken++;
			end
			if (sym_ch.valid && !sym_ch.ready) input_stalls++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

endmodule
